FILE: hdl/egbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package egbw_pkg;

   localparam int WORD_BITS = 32;
   localparam int STREAM_BITS = 2 * WORD_BITS;
   localparam int LEN_W = 7;
   localparam int VALID_W = 6;

   localparam logic [2:0] CMD_RAW   = 3'd0;
   localparam logic [2:0] CMD_UEG   = 3'd1;
   localparam logic [2:0] CMD_SEG   = 3'd2;
   localparam logic [2:0] CMD_ALIGN = 3'd3;
   localparam logic [2:0] CMD_FLUSH = 3'd4;

   localparam logic [1:0] KIND_BITS  = 2'd0;
   localparam logic [1:0] KIND_ALIGN = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   localparam logic [31:0] CW_MAX = 32'h7FFF_FFFF;
   localparam logic [5:0] RAW_MAX = 6'd32;
   localparam logic [VALID_W-1:0] FULL_VALID = 6'd32;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW = $clog2(CMDQ_DEPTH + 1);

   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW = $clog2(RSP_DEPTH);
   localparam int RSP_CW = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [1:0]             kind;
      logic [STREAM_BITS-1:0] bits;
      logic [LEN_W-1:0]       len;
      logic                   fill;
   } item_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [VALID_W-1:0]   valid_bits;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type r0;
      rsp_type r1;
   } rsp_pair_type;

endpackage

`default_nettype wire

FILE: hdl/egbw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module egbw_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [2:0]         req_command,
   input  wire logic [31:0]        req_value,
   input  wire logic [5:0]         req_bit_count,
   input  wire logic               req_align_bit,
   output logic                    item_valid,
   output egbw_pkg::item_type      item,
   input  wire logic               item_ready
);
   import egbw_pkg::*;

   logic        a_valid_ff, a_valid_in;
   logic [2:0]  a_cmd_ff, a_cmd_in;
   logic [31:0] a_data_ff, a_data_in;
   logic [5:0]  a_count_ff, a_count_in;
   logic        a_fill_ff, a_fill_in;
   logic        a_known;
   logic        a_take;
   logic        advance;

   logic [32:0] cw_u;
   logic [31:0] mag;
   logic [33:0] cw_s;
   logic [31:0] x;
   logic [4:0]  pos;

   assign a_take   = req_push && !req_full;
   assign advance  = a_valid_ff && item_ready;
   assign req_full = a_valid_ff && !item_ready;

   // code number plus one, saturated
   always_comb begin
      cw_u = {1'b0, req_value} + 33'd1;
      mag = 32'd0 - req_value;
      cw_s = req_value[31] ? {1'b0, mag, 1'b1} : {1'b0, req_value, req_value == 32'd0};
      a_known = 1'b1;
      a_cmd_in = req_command;
      a_data_in = req_value;
      a_count_in = (req_bit_count > RAW_MAX) ? RAW_MAX : req_bit_count;
      a_fill_in = req_align_bit;
      case (req_command)
         CMD_RAW: begin
            a_cmd_in = CMD_RAW;
         end
         CMD_UEG: begin
            a_cmd_in = CMD_UEG;
            a_data_in = (cw_u > {1'b0, CW_MAX}) ? CW_MAX : cw_u[31:0];
         end
         CMD_SEG: begin
            a_cmd_in = CMD_UEG;
            a_data_in = (cw_s > {2'b00, CW_MAX}) ? CW_MAX : cw_s[31:0];
         end
         CMD_ALIGN: begin
            a_cmd_in = CMD_ALIGN;
         end
         CMD_FLUSH: begin
            a_cmd_in = CMD_FLUSH;
         end
         default: begin
            a_known = 1'b0;
         end
      endcase
      a_valid_in = a_take ? a_known : (a_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         a_cmd_ff   <= a_cmd_in;
         a_data_ff  <= a_data_in;
         a_count_ff <= a_count_in;
         a_fill_ff  <= a_fill_in;
      end
   end

   // position of the leading one, binary search
   always_comb begin
      x = a_data_ff;
      pos = 5'd0;
      if (x[31:16] != 16'd0) begin
         pos[4] = 1'b1;
         x = x >> 16;
      end
      if (x[15:8] != 8'd0) begin
         pos[3] = 1'b1;
         x = x >> 8;
      end
      if (x[7:4] != 4'd0) begin
         pos[2] = 1'b1;
         x = x >> 4;
      end
      if (x[3:2] != 2'd0) begin
         pos[1] = 1'b1;
         x = x >> 2;
      end
      if (x[1] != 1'b0) begin
         pos[0] = 1'b1;
      end
   end

   // left-aligned code bits and their length
   always_comb begin
      item_valid = a_valid_ff;
      item.kind = KIND_BITS;
      item.bits = '0;
      item.len = '0;
      item.fill = a_fill_ff;
      case (a_cmd_ff)
         CMD_RAW: begin
            item.bits = {a_data_ff, 32'd0} << (6'd32 - a_count_ff);
            item.len = {1'b0, a_count_ff};
         end
         CMD_UEG: begin
            item.bits = {32'd0, a_data_ff} << (6'd63 - {pos, 1'b0});
            item.len = {1'b0, pos, 1'b1};
         end
         CMD_ALIGN: begin
            item.kind = KIND_ALIGN;
         end
         CMD_FLUSH: begin
            item.kind = KIND_FLUSH;
         end
         default: begin
            item.kind = KIND_BITS;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/egbw_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module egbw_cmd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire egbw_pkg::item_type in_item,
   output logic                    in_ready,
   output logic                    out_valid,
   output egbw_pkg::item_type      out_item,
   input  wire logic               out_pop
);
   import egbw_pkg::*;

   item_type             q_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0]   count_ff, count_in;
   logic                 push;
   logic                 pop;

   assign in_ready  = count_ff < CMDQ_CW'(CMDQ_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMDQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + CMDQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CMDQ_CW'(push) - CMDQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/egbw_back.sv
`timescale 1ns / 1ps
`default_nettype none

module egbw_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire egbw_pkg::item_type item,
   output logic                    item_pop,
   input  wire logic               space_ok,
   output egbw_pkg::rsp_pair_type  pair
);
   import egbw_pkg::*;

   logic [WORD_BITS-1:0]     pend_ff, pend_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic                     take;
   logic [2:0]               pad;
   logic [STREAM_BITS-1:0]   ins_bits;
   logic [LEN_W-1:0]         ins_len;
   logic [LEN_W-1:0]         total;
   logic [3*WORD_BITS-1:0]   win;

   assign take     = item_valid && space_ok;
   assign item_pop = take;

   always_comb begin
      pad = 3'd0 - cnt_ff[2:0];
      if (item.kind == KIND_ALIGN) begin
         ins_bits = item.fill ? ~({STREAM_BITS{1'b1}} >> pad) : '0;
         ins_len = {4'd0, pad};
      end else begin
         ins_bits = item.bits;
         ins_len = item.len;
      end
      total = {2'b00, cnt_ff} + ins_len;
      win = {pend_ff, {STREAM_BITS{1'b0}}} | ({ins_bits, {WORD_BITS{1'b0}}} >> cnt_ff);

      pend_in = pend_ff;
      cnt_in = cnt_ff;
      pair = '0;
      if (take) begin
         if (item.kind == KIND_FLUSH) begin
            pend_in = '0;
            cnt_in = '0;
            if (cnt_ff != 5'd0) begin
               pair.push0 = 1'b1;
               pair.r0 = '{word: pend_ff, valid_bits: {1'b0, cnt_ff}, last: 1'b1};
            end
         end else begin
            cnt_in = total[4:0];
            if (total < 7'd32) begin
               pend_in = win[95:64];
            end else if (total < 7'd64) begin
               pair.push0 = 1'b1;
               pair.r0 = '{word: win[95:64], valid_bits: FULL_VALID, last: 1'b1};
               pend_in = win[63:32];
            end else begin
               pair.push0 = 1'b1;
               pair.push1 = 1'b1;
               pair.r0 = '{word: win[95:64], valid_bits: FULL_VALID, last: 1'b0};
               pair.r1 = '{word: win[63:32], valid_bits: FULL_VALID, last: 1'b1};
               pend_in = win[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

   // bits past the pending count stay zero
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff & ({WORD_BITS{1'b1}} >> cnt_ff)) == '0)
      else $error("pending word has bits beyond its count");

   assert property (@(posedge clock) disable iff (reset)
      (take && item.kind == KIND_FLUSH) |=> (cnt_ff == 5'd0 && pend_ff == '0))
      else $error("flush did not empty the pending word");

endmodule

`default_nettype wire

FILE: hdl/egbw_rsp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module egbw_rsp_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire egbw_pkg::rsp_pair_type pair,
   output logic                        space_ok,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output egbw_pkg::rsp_type           head
);
   import egbw_pkg::*;

   rsp_type            mem_ff [RSP_DEPTH];
   logic [RSP_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CW-1:0]  count_ff, count_in;
   logic               pop;

   assign rsp_empty = count_ff == '0;
   assign head      = mem_ff[rd_ptr_ff];
   assign pop       = rsp_pop && !rsp_empty;
   assign space_ok  = count_ff <= RSP_CW'(RSP_DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_AW'(pair.push0) + RSP_AW'(pair.push1);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CW'(pair.push0) + RSP_CW'(pair.push1) - RSP_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair.push0) begin
         mem_ff[wr_ptr_ff] <= pair.r0;
      end
      if (pair.push1) begin
         mem_ff[wr_ptr_ff + RSP_AW'(1)] <= pair.r1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CW'(RSP_DEPTH))
      else $error("result queue count out of range");

   assert property (@(posedge clock) disable iff (reset)
      pair.push0 |-> count_ff <= RSP_CW'(RSP_DEPTH - 2))
      else $error("result words pushed without room");

   assert property (@(posedge clock) disable iff (reset)
      pair.push1 |-> (pair.push0 && pair.r1.last && !pair.r0.last))
      else $error("second word without a first");

endmodule

`default_nettype wire

FILE: hdl/exp_golomb_bit_writer.sv
// path: front register, command queue, then packer into the result queue
// throughput: one item per cycle while the result queue has room; each stage takes one
// the result queue drains one word per cycle, so an item filling two words uses an extra
// word slot of result bandwidth, and push is held off once the queues back up
// reset: synchronous, clears the pending word and count and empties both queues
`timescale 1ns / 1ps
`default_nettype none

module exp_golomb_bit_writer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [2:0]  req_command,
   input  wire logic [31:0] req_value,
   input  wire logic [5:0]  req_bit_count,
   input  wire logic        req_align_bit,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_word,
   output logic [5:0]       rsp_valid_bits,
   output logic             rsp_last
);
   import egbw_pkg::*;

   logic         f_valid;
   item_type     f_item;
   logic         f_ready;
   logic         q_valid;
   item_type     q_item;
   logic         q_pop;
   logic         space_ok;
   rsp_pair_type pair;
   rsp_type      head;

   egbw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_value     (req_value),
      .req_bit_count (req_bit_count),
      .req_align_bit (req_align_bit),
      .item_valid    (f_valid),
      .item          (f_item),
      .item_ready    (f_ready)
   );

   egbw_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_item   (f_item),
      .in_ready  (f_ready),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_pop   (q_pop)
   );

   egbw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_item),
      .item_pop   (q_pop),
      .space_ok   (space_ok),
      .pair       (pair)
   );

   egbw_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .space_ok  (space_ok),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (head)
   );

   assign rsp_word       = head.word;
   assign rsp_valid_bits = head.valid_bits;
   assign rsp_last       = head.last;

endmodule

`default_nettype wire
